@@ hdl/gsa_pkg.sv @@
// ---------------------------------------------------------------------------
// gsa_pkg
// Shared sizes, command and status codes and controller states for the
// generational slot allocator.
// ---------------------------------------------------------------------------
package gsa_pkg;

	// table geometry
	localparam int SLOTS  = 256;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int GEN_W  = 16;
	// slot word: alive flag over generation
	localparam int SLOT_W = GEN_W + 1;

	// command codes (any other code resolves)
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_NULL  = 2'd2,
		STAT_STALE = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_ALLOC_GEN,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

@@ hdl/gsa_ram.sv @@
// ---------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/generational_slot_allocator_core.sv @@
// ---------------------------------------------------------------------------
// generational_slot_allocator_core
// Hands out table slots as index-plus-generation handles: allocate, release
// and resolve, with a LIFO free stack and a generation/alive RAM.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  req     | req_valid, req_stall | cmd, handle_index, handle_generation
//  rsp     | rsp_valid, rsp_stall | ok, status, out_index, out_generation
//
//  a fresh allocate or a rejected command goes straight to done; release
//  and resolve pass check (one slot RAM read); an allocate from the free
//  stack via pop, alloc_gen (stack, then slot RAM read); rsp_stall holds done.
//  one item at a time; req_stall is high from acceptance until the result
//  moves into the output register, which may still hold an earlier result.
//  reset clears counters and control; RAM contents need no clearing.
// ---------------------------------------------------------------------------
module generational_slot_allocator_core
	import gsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [1:0]       cmd,
	input  logic [IDX_W-1:0] handle_index,
	input  logic [GEN_W-1:0] handle_generation,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic             ok,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] out_index,
	output logic [GEN_W-1:0] out_generation
);

	state_t state_q, state_d;

	// latched item
	logic [1:0]       cmd_q, cmd_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [GEN_W-1:0] hgen_q, hgen_d;

	// counters
	logic [CNT_W-1:0] free_cnt_q, free_cnt_d;
	logic [CNT_W-1:0] used_q, used_d;

	// pending result
	logic             res_ok_q, res_ok_d;
	status_t          res_stat_q, res_stat_d;
	logic [IDX_W-1:0] res_idx_q, res_idx_d;
	logic [GEN_W-1:0] res_gen_q, res_gen_d;

	// output register
	logic             rsp_valid_q;
	logic             out_ok_q;
	status_t          out_stat_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [GEN_W-1:0] out_gen_q;

	// ram ports
	logic              gen_wr_en, gen_rd_en;
	logic [IDX_W-1:0]  gen_wr_addr, gen_rd_addr;
	logic [SLOT_W-1:0] gen_wr_data, gen_rd_data;
	logic              stk_wr_en, stk_rd_en;
	logic [IDX_W-1:0]  stk_wr_addr, stk_rd_addr;
	logic [IDX_W-1:0]  stk_wr_data, stk_rd_data;

	// decode helpers
	logic             accept;
	logic             out_free;
	logic             take_pop;
	logic             handle_bad;
	logic             rd_alive;
	logic [GEN_W-1:0] rd_gen;
	logic [GEN_W-1:0] rd_gen_fix;
	logic [GEN_W-1:0] rd_gen_inc;
	logic             live_match;

	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign take_pop   = (free_cnt_q != '0);
	assign handle_bad = (handle_generation == '0) || ({1'b0, handle_index} >= used_q);
	assign rd_alive   = gen_rd_data[GEN_W];
	assign rd_gen     = gen_rd_data[GEN_W-1:0];
	assign rd_gen_fix = (rd_gen == '0) ? GEN_W'(1) : rd_gen;
	assign rd_gen_inc = ((rd_gen + GEN_W'(1)) == '0) ? GEN_W'(1) : (rd_gen + GEN_W'(1));
	assign live_match = rd_alive && (rd_gen == hgen_q);

	// slot word ram: alive flag and generation
	gsa_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (gen_wr_en),
		.wr_addr (gen_wr_addr),
		.wr_data (gen_wr_data),
		.rd_en   (gen_rd_en),
		.rd_addr (gen_rd_addr),
		.rd_data (gen_rd_data)
	);

	// free stack ram
	gsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOTS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (stk_rd_en),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_ALLOC) begin
						state_d = take_pop ? ST_POP : ST_DONE;
					end else begin
						state_d = handle_bad ? ST_DONE : ST_CHECK;
					end
				end
			end
			ST_POP:       state_d = ST_ALLOC_GEN;
			ST_ALLOC_GEN: state_d = ST_DONE;
			ST_CHECK:     state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory control, counters and result
	always_comb begin
		cmd_d       = cmd_q;
		idx_d       = idx_q;
		hgen_d      = hgen_q;
		free_cnt_d  = free_cnt_q;
		used_d      = used_q;
		res_ok_d    = res_ok_q;
		res_stat_d  = res_stat_q;
		res_idx_d   = res_idx_q;
		res_gen_d   = res_gen_q;
		gen_wr_en   = 1'b0;
		gen_wr_addr = idx_q;
		gen_wr_data = {1'b1, rd_gen_fix};
		gen_rd_en   = 1'b0;
		gen_rd_addr = handle_index;
		stk_wr_en   = 1'b0;
		stk_wr_addr = free_cnt_q[IDX_W-1:0];
		stk_wr_data = idx_q;
		stk_rd_en   = 1'b0;
		stk_rd_addr = free_cnt_q[IDX_W-1:0] - IDX_W'(1);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_d  = cmd;
					idx_d  = handle_index;
					hgen_d = handle_generation;
					if (cmd == CMD_ALLOC) begin
						if (take_pop) begin
							stk_rd_en = 1'b1;
						end else if (used_q != CNT_W'(SLOTS)) begin
							// fresh slot starts alive at generation one
							gen_wr_en   = 1'b1;
							gen_wr_addr = used_q[IDX_W-1:0];
							gen_wr_data = {1'b1, GEN_W'(1)};
							used_d      = used_q + CNT_W'(1);
							res_ok_d    = 1'b1;
							res_stat_d  = STAT_OK;
							res_idx_d   = used_q[IDX_W-1:0];
							res_gen_d   = GEN_W'(1);
						end else begin
							res_ok_d   = 1'b0;
							res_stat_d = STAT_FULL;
							res_idx_d  = '0;
							res_gen_d  = '0;
						end
					end else if (handle_bad) begin
						res_ok_d   = 1'b0;
						res_stat_d = STAT_NULL;
						res_idx_d  = handle_index;
						res_gen_d  = handle_generation;
					end else begin
						gen_rd_en = 1'b1;
					end
				end
			end
			ST_POP: begin
				// popped index addresses the slot ram
				free_cnt_d  = free_cnt_q - CNT_W'(1);
				idx_d       = stk_rd_data;
				gen_rd_en   = 1'b1;
				gen_rd_addr = stk_rd_data;
			end
			ST_ALLOC_GEN: begin
				gen_wr_en  = 1'b1;
				res_ok_d   = 1'b1;
				res_stat_d = STAT_OK;
				res_idx_d  = idx_q;
				res_gen_d  = rd_gen_fix;
			end
			ST_CHECK: begin
				res_idx_d = idx_q;
				res_gen_d = hgen_q;
				if (!live_match) begin
					res_ok_d   = 1'b0;
					res_stat_d = STAT_STALE;
				end else begin
					res_ok_d   = 1'b1;
					res_stat_d = STAT_OK;
					if (cmd_q == CMD_RELEASE) begin
						// retire slot, bump generation, push index
						gen_wr_en   = 1'b1;
						gen_wr_data = {1'b0, rd_gen_inc};
						if (free_cnt_q != CNT_W'(SLOTS)) begin
							stk_wr_en  = 1'b1;
							free_cnt_d = free_cnt_q + CNT_W'(1);
						end
					end
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_cnt_q  <= '0;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_cnt_q <= free_cnt_d;
			used_q     <= used_d;
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		idx_q      <= idx_d;
		hgen_q     <= hgen_d;
		res_ok_q   <= res_ok_d;
		res_stat_q <= res_stat_d;
		res_idx_q  <= res_idx_d;
		res_gen_q  <= res_gen_d;
		if (state_q == ST_DONE && out_free) begin
			out_ok_q   <= res_ok_q;
			out_stat_q <= res_stat_q;
			out_idx_q  <= res_idx_q;
			out_gen_q  <= res_gen_q;
		end
	end

	assign req_stall      = (state_q != ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign ok             = out_ok_q;
	assign status         = out_stat_q;
	assign out_index      = out_idx_q;
	assign out_generation = out_gen_q;

`ifndef SYNTHESIS
	// free slots never outnumber slots ever handed out
	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= used_q)
		else $error("free count exceeds used slots");

	// used slot count stays within the table
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(SLOTS))
		else $error("used slot count out of range");

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start");

	// results appear only from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// a stored generation is never null
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_wr_en |-> gen_wr_data[GEN_W-1:0] != '0)
		else $error("null generation written");
`endif

endmodule
